// ----- design/rwa_pkg.sv -----
// Shared types and constants for the running window average core.
// Holds widths, opcodes and the controller/datapath command and status structs.
// No dependencies.
package rwa_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int SLOT_W       = $clog2(WINDOW_MAX);
    localparam int LEN_W        = SLOT_W + 1;
    localparam int SUM_W        = SAMPLE_WIDTH + SLOT_W;
    localparam int DIV_STEPS    = SUM_W;
    localparam int STEP_W       = $clog2(DIV_STEPS + 1);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(WINDOW_MAX);

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_CLEAR = 1'b1
    } rwa_op_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic update;
        logic div_start;
        logic emit;
    } rwa_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } rwa_status_t;

endpackage

// ----- design/rwa_div.sv -----
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Divides the window sum magnitude by the fill count; uses rwa_pkg.
module rwa_div
    import rwa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [LEN_W-1:0]  divisor,
    output logic              done,
    output logic [SUM_W-1:0]  quotient
);

    logic [SUM_W-1:0]  quo_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [LEN_W:0]    trial;
    logic              fits;
    logic [LEN_W:0]    diff;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/rwa_dp.sv -----
// Datapath: window length register, sample ring, running sum, slot and fill count,
// divider and output register. Uses rwa_pkg and rwa_div.
module rwa_dp
    import rwa_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rwa_cmd_t                cmd,
    output rwa_status_t             status,
    input  logic                    cfg_wr_en,
    input  logic [LEN_W-1:0]        cfg_wr_data,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [SAMPLE_WIDTH-1:0] m_tdata,
    output logic                    m_tuser
);

    logic [LEN_W-1:0]        window_length_reg;
    logic [LEN_W-1:0]        len_eff;

    logic [SAMPLE_WIDTH-1:0] ring_mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]   valid_reg;
    logic [SAMPLE_WIDTH-1:0] old_reg;
    logic                    old_valid_reg;

    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic [SLOT_W-1:0]       slot_reg;
    logic [SLOT_W-1:0]       slot_next;
    logic [LEN_W-1:0]        slot_inc;
    logic [LEN_W-1:0]        fill_reg;
    logic [LEN_W-1:0]        fill_next;
    logic                    full_reg;

    logic [SUM_W-1:0]        sum_mag;
    logic                    div_done;
    logic [SUM_W-1:0]        quotient;
    logic [SAMPLE_WIDTH-1:0] avg_sat;

    logic                    m_tvalid_reg;
    logic [SAMPLE_WIDTH-1:0] m_tdata_reg;
    logic                    m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= LEN_RESET;
        end else if (cfg_wr_en) begin
            window_length_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (window_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (window_length_reg > LEN_W'(WINDOW_MAX)) begin
            len_eff = LEN_W'(WINDOW_MAX);
        end else begin
            len_eff = window_length_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            ring_mem[slot_reg] <= sample_reg;
        end
        old_reg <= ring_mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            old_valid_reg <= 1'b0;
        end else begin
            old_valid_reg <= valid_reg[slot_reg];
            if (cmd.clear) begin
                valid_reg <= '0;
            end else if (cmd.update) begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= sample;
        end
    end

    always_comb begin
        sum_next = sum_reg + {{(SUM_W-SAMPLE_WIDTH){sample_reg[SAMPLE_WIDTH-1]}}, sample_reg};
        if (old_valid_reg) begin
            sum_next = sum_next - {{(SUM_W-SAMPLE_WIDTH){old_reg[SAMPLE_WIDTH-1]}}, old_reg};
        end
        slot_inc  = {1'b0, slot_reg} + LEN_W'(1);
        slot_next = (slot_inc >= len_eff) ? '0 : slot_inc[SLOT_W-1:0];
        fill_next = (fill_reg < len_eff) ? fill_reg + LEN_W'(1) : fill_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            slot_reg <= '0;
            fill_reg <= '0;
            full_reg <= 1'b0;
        end else if (cmd.clear) begin
            sum_reg  <= '0;
            slot_reg <= '0;
            fill_reg <= '0;
        end else if (cmd.update) begin
            sum_reg  <= sum_next;
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            full_reg <= (fill_next >= len_eff);
        end
    end

    assign sum_mag = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;

    rwa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_mag),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // saturate to the sample range, then restore the sign
    always_comb begin
        if (sum_reg[SUM_W-1]) begin
            if (quotient > SUM_W'(1 << (SAMPLE_WIDTH - 1))) begin
                avg_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            end else begin
                avg_sat = ~quotient[SAMPLE_WIDTH-1:0] + SAMPLE_WIDTH'(1);
            end
        end else begin
            if (quotient > SUM_W'((1 << (SAMPLE_WIDTH - 1)) - 1)) begin
                avg_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            end else begin
                avg_sat = quotient[SAMPLE_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= avg_sat;
            m_tuser_reg <= full_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.out_busy = m_tvalid_reg & ~m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- design/rwa_ctrl.sv -----
// Controller state machine: accepts a word, sequences update, divide and emit.
// Drives datapath commands from datapath status; uses rwa_pkg.
module rwa_ctrl
    import rwa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        opcode,
    input  rwa_status_t status,
    output rwa_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_START  = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (opcode == OP_CLEAR) begin
                        cmd.clear = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_START;
            end
            S_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVIDE;
            end
            S_DIVIDE: begin
                if (status.div_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/running_window_average_core.sv -----
// Running window average core: moving average over the last window_length samples.
// Top level; joins rwa_ctrl and rwa_dp, uses rwa_pkg.
//
// Input stream (s_*): s_tdata carries the signed 16-bit sample, s_tuser the opcode
// (push or clear). A push emits one word on m_*; a clear empties the ring, zeroes the sum,
// slot and fill count and emits nothing.
// Output stream (m_*): m_tdata is the signed 16-bit average, truncated toward zero
// and saturated; m_tuser is high once the fill count has reached the window length.
// Configuration: cfg_wr_en writes cfg_wr_data into window_length (0 acts as 1,
// above 64 acts as 64). Write it only while the core is idle.
// Sequence: an accepted push is followed by an update step, a divider load step,
// the bit-serial divider over the 22-bit sum, the controller seeing the divider
// finish, and the write into the output register. s_tready is high only while the
// controller is idle, so the core takes no new push until it is through with the
// last one.
// Stall: a held result stays in the output register; the next push may be
// accepted meanwhile and waits before its own emit until the register frees.
// Reset (aresetn low, synchronous): window length 64, ring reads as zero, sum,
// slot and fill count zero, output empty.
module running_window_average_core
    import rwa_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [LEN_W-1:0]        cfg_wr_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [SAMPLE_WIDTH-1:0] s_tdata,   // [15:0] sample
    input  logic                    s_tuser,   // [0] opcode
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [SAMPLE_WIDTH-1:0] m_tdata,   // [15:0] average
    output logic                    m_tuser    // [0] window_full
);

    rwa_cmd_t    cmd;
    rwa_status_t status;

    rwa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    rwa_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
